>>> rtl/page_slot_admission_eviction_assert.svh
// ---------------------------------------------------------------------------
// page slot admission and eviction: assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ---------------------------------------------------------------------------
`ifndef PAGE_SLOT_ADMISSION_EVICTION_ASSERT_SVH
`define PAGE_SLOT_ADMISSION_EVICTION_ASSERT_SVH

// same-cycle implication
`define PSAE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSAE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/psae_pkg.sv
// ---------------------------------------------------------------------------
// psae_pkg
// shared codes, constants and helpers of the page slot admission block
// ---------------------------------------------------------------------------
package psae_pkg;

   localparam int NUM_PAGES_DEF  = 64;
   localparam int NUM_CHUNKS_DEF = 4096;

   localparam logic [31:0] ADMIT_MARGIN     = 32'h0080_0000;
   localparam logic [31:0] IDLE_FREE_FRAMES = 32'd12;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PROTECT_W  = 8;
   localparam int CHUNKS_W   = 13;
   localparam int PAGES_W    = 7;

   localparam logic [CSR_IDX_W-1:0] REG_PROTECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAGES   = 2'd2;

   localparam logic [PROTECT_W-1:0] PROTECT_RST = 8'd2;
   localparam logic [CHUNKS_W-1:0]  CHUNKS_RST  = 13'd4096;
   localparam logic [PAGES_W-1:0]   PAGES_RST   = 7'd64;

   typedef enum logic [2:0] {
      MODE_REQUEST = 3'd0,
      MODE_TICK    = 3'd1,
      MODE_UP_DONE = 3'd2,
      MODE_UP_FAIL = 3'd3,
      MODE_TOUCH   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STAT_ADMITTED = 3'd0,
      STAT_ACTIVE   = 3'd1,
      STAT_NO_SLOT  = 3'd2,
      STAT_REFUSED  = 3'd3,
      STAT_INVALID  = 3'd4,
      STAT_DONE     = 3'd5
   } status_type;

   typedef struct packed {
      logic found_load;
      logic found_free;
      logic have_best;
   } scan_flags_type;

   // priority reads as zero once the page sat idle too many frames
   function automatic logic [31:0] eff_prio(input logic [31:0] prio,
                                            input logic [31:0] touch,
                                            input logic [31:0] frame);
      logic [31:0] t;
      logic [31:0] age;
      t   = (touch < frame) ? touch : frame;
      age = frame - t;
      return (age > IDLE_FREE_FRAMES) ? 32'd0 : prio;
   endfunction

endpackage

>>> rtl/psae_ram.sv
// ---------------------------------------------------------------------------
// psae_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module psae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/psae_scan.sv
// ---------------------------------------------------------------------------
// psae_scan
// walks the slot records one a cycle: loading match, first free, best victim
// ---------------------------------------------------------------------------
module psae_scan #(
   parameter int NUM_PAGES  = psae_pkg::NUM_PAGES_DEF,
   parameter int NUM_CHUNKS = psae_pkg::NUM_CHUNKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(NUM_PAGES+1)-1:0]       pages,
   input  logic [$clog2(NUM_CHUNKS)-1:0]        chunk,
   input  logic [31:0]                          frame,
   input  logic                                 rec_chunk_v,
   input  logic                                 rec_load_v,
   input  logic [$clog2(NUM_CHUNKS)-1:0]        rec_load,
   input  logic                                 rec_pin,
   input  logic [31:0]                          rec_protect,
   input  logic [31:0]                          rec_stamp,
   input  logic [31:0]                          rec_prio,
   input  logic [31:0]                          rec_touch,
   output logic [$clog2(NUM_PAGES)-1:0]         rd_addr,
   output logic                                 done,
   output psae_pkg::scan_flags_type             flags,
   output logic [$clog2(NUM_PAGES)-1:0]         load_slot,
   output logic [$clog2(NUM_PAGES)-1:0]         free_slot,
   output logic [$clog2(NUM_PAGES)-1:0]         best_slot,
   output logic [31:0]                          best_prio
);

   localparam int SW  = $clog2(NUM_PAGES);
   localparam int PCW = $clog2(NUM_PAGES+1);

   logic                     issuing_ff, issuing_in;
   logic [PCW-1:0]           issue_ff, issue_in;
   logic                     proc_v_ff, proc_v_in;
   logic [SW-1:0]            proc_idx_ff, proc_idx_in;
   logic                     done_ff, done_in;
   psae_pkg::scan_flags_type flags_ff, flags_in;
   logic [SW-1:0]            load_ff, load_in;
   logic [SW-1:0]            free_ff, free_in;
   logic [SW-1:0]            best_ff, best_in;
   logic [31:0]              best_pr_ff, best_pr_in;
   logic [31:0]              best_st_ff, best_st_in;

   logic        is_match, is_free, is_cand, better;
   logic [31:0] pr;

   always_comb begin
      is_match = rec_load_v && (rec_load == chunk);
      is_free  = !rec_chunk_v && !rec_load_v;
      is_cand  = !rec_pin && !rec_load_v && !(rec_protect > frame);
      pr       = (frame != 32'd0) ? psae_pkg::eff_prio(rec_prio, rec_touch, frame) : 32'd0;
      better   = !flags_ff.have_best || (pr < best_pr_ff) ||
                 ((pr == best_pr_ff) && (rec_stamp < best_st_ff));

      issuing_in  = issuing_ff;
      issue_in    = issue_ff;
      proc_v_in   = issuing_ff;
      proc_idx_in = issue_ff[SW-1:0];
      done_in     = 1'b0;
      flags_in    = flags_ff;
      load_in     = load_ff;
      free_in     = free_ff;
      best_in     = best_ff;
      best_pr_in  = best_pr_ff;
      best_st_in  = best_st_ff;

      if (start) begin
         issuing_in = 1'b1;
         issue_in   = '0;
         proc_v_in  = 1'b0;
         flags_in   = '0;
      end else begin
         if (issuing_ff) begin
            issue_in = issue_ff + PCW'(1);
            if (issue_ff == pages - PCW'(1)) begin
               issuing_in = 1'b0;
            end
         end
         if (proc_v_ff) begin
            if (is_match && !flags_ff.found_load) begin
               flags_in.found_load = 1'b1;
               load_in             = proc_idx_ff;
            end
            if (is_free && !flags_ff.found_free) begin
               flags_in.found_free = 1'b1;
               free_in             = proc_idx_ff;
            end
            if (is_cand && better) begin
               flags_in.have_best = 1'b1;
               best_in            = proc_idx_ff;
               best_pr_in         = pr;
               best_st_in         = rec_stamp;
            end
            done_in = (PCW'(proc_idx_ff) == pages - PCW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         proc_v_ff  <= 1'b0;
         done_ff    <= 1'b0;
         flags_ff   <= '0;
      end else begin
         issuing_ff <= issuing_in;
         proc_v_ff  <= proc_v_in;
         done_ff    <= done_in;
         flags_ff   <= flags_in;
      end
      issue_ff    <= issue_in;
      proc_idx_ff <= proc_idx_in;
      load_ff     <= load_in;
      free_ff     <= free_in;
      best_ff     <= best_in;
      best_pr_ff  <= best_pr_in;
      best_st_ff  <= best_st_in;
   end

   assign rd_addr   = issue_ff[SW-1:0];
   assign done      = done_ff;
   assign flags     = flags_ff;
   assign load_slot = load_ff;
   assign free_slot = free_ff;
   assign best_slot = best_ff;
   assign best_prio = best_pr_ff;

endmodule

>>> rtl/page_slot_admission_eviction.sv
// ---------------------------------------------------------------------------
// page_slot_admission_eviction
// page slot table with chunk map: admission, publish, touch, frame tick
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  req_     in   req_valid/req_stall  mode, chunk, slot, priority, pin
//  rsp_     out  rsp_valid/rsp_stall  status, slot, displaced, resident count
//  csr_     in   csr_wr_en            index, data (no read-back)
//
// one word at a time; each passes fetch, decide and response, a touch or a
// mapped request adds a slot record read and write, a publish over another
// chunk a map read and write, and a request that misses the map first scans
// the slot ram one record a cycle. after reset, and after a write of
// chunks_in_use or pages_in_use, the chunk map ram is swept clear, one entry
// a cycle, with req_stall high. a stalled result sits in the output register
// while the next word is taken; the next result waits for it.
// ---------------------------------------------------------------------------
`include "page_slot_admission_eviction_assert.svh"

module page_slot_admission_eviction #(
   parameter int NUM_PAGES  = psae_pkg::NUM_PAGES_DEF,
   parameter int NUM_CHUNKS = psae_pkg::NUM_CHUNKS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_mode,
   input  logic [$clog2(NUM_CHUNKS)-1:0]         req_chunk_id,
   input  logic [$clog2(NUM_PAGES)-1:0]          req_slot_index,
   input  logic [31:0]                           req_want_priority,
   input  logic                                  req_pin_request,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_status,
   output logic [$clog2(NUM_PAGES)-1:0]          rsp_chosen_slot,
   output logic                                  rsp_displaced_valid,
   output logic [$clog2(NUM_CHUNKS)-1:0]         rsp_displaced_chunk,
   output logic [$clog2(NUM_PAGES+1)-1:0]        rsp_resident_count,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [psae_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psae_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SW  = $clog2(NUM_PAGES);
   localparam int CW  = $clog2(NUM_CHUNKS);
   localparam int PCW = $clog2(NUM_PAGES+1);
   localparam int MW  = SW + 1;

   // slot record layout, touch frame in the low bits
   localparam int O_PRIO  = 32;
   localparam int O_STAMP = 64;
   localparam int O_PROT  = 96;
   localparam int O_PIN   = 128;
   localparam int O_LOAD  = 129;
   localparam int O_LV    = 129 + CW;
   localparam int O_CHUNK = 130 + CW;
   localparam int O_CV    = 130 + 2*CW;
   localparam int RW      = 131 + 2*CW;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECIDE, ST_SCAN,
      ST_RMW_RD, ST_RMW_WR, ST_OLD_RD, ST_OLD_WR, ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             mode_ff, mode_in;
   logic [CW-1:0]          chunk_ff, chunk_in;
   logic [SW-1:0]          sidx_ff, sidx_in;
   logic [31:0]            want_ff, want_in;
   logic                   pin_ff, pin_in;
   logic [SW-1:0]          tgt_ff, tgt_in;
   logic                   admit_ff, admit_in;
   logic [CW-1:0]          old_ff, old_in;
   psae_pkg::status_type   res_status_ff, res_status_in;
   logic [SW-1:0]          res_chosen_ff, res_chosen_in;
   logic                   res_dv_ff, res_dv_in;
   logic [CW-1:0]          res_dc_ff, res_dc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   psae_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [SW-1:0]          rsp_chosen_ff, rsp_chosen_in;
   logic                   rsp_dv_ff, rsp_dv_in;
   logic [CW-1:0]          rsp_dc_ff, rsp_dc_in;
   logic [PCW-1:0]         rsp_res_ff, rsp_res_in;
   logic [31:0]            frame_ff, frame_in;
   logic [31:0]            use_clock_ff, use_clock_in;
   logic [PCW-1:0]         resident_ff, resident_in;
   logic [psae_pkg::PROTECT_W-1:0] protect_cfg_ff, protect_cfg_in;
   logic [psae_pkg::CHUNKS_W-1:0]  chunks_cfg_ff, chunks_cfg_in;
   logic [psae_pkg::PAGES_W-1:0]   pages_cfg_ff, pages_cfg_in;
   logic [CW-1:0]          clr_ff, clr_in;
   logic [NUM_PAGES-1:0]   slot_vld_ff, slot_vld_in;
   logic                   vld_q_ff, vld_q_in;

   // ram ports
   logic          s_we;
   logic [SW-1:0] s_waddr, s_raddr;
   logic [RW-1:0] s_wdata, s_rdata, rec;
   logic          m_we;
   logic [CW-1:0] m_waddr, m_raddr;
   logic [MW-1:0] m_wdata, m_rdata;

   // unpacked record read and the record written back
   logic          r_cv, r_lv, r_pin;
   logic [CW-1:0] r_chunk, r_load;
   logic [31:0]   r_prot, r_stamp, r_prio, r_touch;
   logic          w_cv, w_lv, w_pin;
   logic [CW-1:0] w_chunk, w_load;
   logic [31:0]   w_prot, w_stamp, w_prio, w_touch;

   // scan unit
   logic                     scan_start, scan_done;
   logic [SW-1:0]            scan_addr, scan_load, scan_free, scan_best;
   logic [31:0]              scan_best_pr;
   psae_pkg::scan_flags_type scan_flags;

   // derived limits and checks
   logic [31:0]    eff_chunks, pages_min, eff_pages32;
   logic [PCW-1:0] pages;
   logic           chunk_ok, sidx_ok, map_cur_ok, accept, cfg_clear;
   logic           load_match, chunk_match;
   logic [31:0]    next_stamp, touch_pr, bar;

   psae_ram #(.WIDTH(RW), .DEPTH(NUM_PAGES)) u_slot_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   psae_ram #(.WIDTH(MW), .DEPTH(NUM_CHUNKS)) u_map_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   psae_scan #(.NUM_PAGES(NUM_PAGES), .NUM_CHUNKS(NUM_CHUNKS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .pages       (pages),
      .chunk       (chunk_ff),
      .frame       (frame_ff),
      .rec_chunk_v (r_cv),
      .rec_load_v  (r_lv),
      .rec_load    (r_load),
      .rec_pin     (r_pin),
      .rec_protect (r_prot),
      .rec_stamp   (r_stamp),
      .rec_prio    (r_prio),
      .rec_touch   (r_touch),
      .rd_addr     (scan_addr),
      .done        (scan_done),
      .flags       (scan_flags),
      .load_slot   (scan_load),
      .free_slot   (scan_free),
      .best_slot   (scan_best),
      .best_prio   (scan_best_pr)
   );

   // never-written slots read as the cleared record
   assign rec     = vld_q_ff ? s_rdata : '0;
   assign r_touch = rec[31:0];
   assign r_prio  = rec[O_PRIO+31:O_PRIO];
   assign r_stamp = rec[O_STAMP+31:O_STAMP];
   assign r_prot  = rec[O_PROT+31:O_PROT];
   assign r_pin   = rec[O_PIN];
   assign r_load  = rec[O_LOAD+CW-1:O_LOAD];
   assign r_lv    = rec[O_LV];
   assign r_chunk = rec[O_CHUNK+CW-1:O_CHUNK];
   assign r_cv    = rec[O_CV];
   assign s_wdata = {w_cv, w_chunk, w_lv, w_load, w_pin, w_prot, w_stamp, w_prio, w_touch};

   // effective chunk and page counts
   always_comb begin
      eff_chunks  = (32'(chunks_cfg_ff) < 32'(NUM_CHUNKS)) ? 32'(chunks_cfg_ff)
                                                            : 32'(NUM_CHUNKS);
      pages_min   = (32'(pages_cfg_ff) < 32'(NUM_PAGES)) ? 32'(pages_cfg_ff)
                                                          : 32'(NUM_PAGES);
      eff_pages32 = (pages_min < eff_chunks) ? pages_min : eff_chunks;
      pages       = eff_pages32[PCW-1:0];
   end

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign chunk_ok    = 32'(chunk_ff) < eff_chunks;
   assign sidx_ok     = PCW'(sidx_ff) < pages;
   assign map_cur_ok  = m_rdata[MW-1] && (PCW'(m_rdata[SW-1:0]) < pages);
   assign load_match  = r_lv && (r_load == chunk_ff);
   assign chunk_match = r_cv && (r_chunk == chunk_ff);
   assign next_stamp  = use_clock_ff + 32'd1;
   assign cfg_clear   = csr_wr_en &&
                        ((csr_index == psae_pkg::REG_CHUNKS) || (csr_index == psae_pkg::REG_PAGES));

   // margin bar, saturating
   assign bar = (scan_best_pr > (32'hFFFF_FFFF - psae_pkg::ADMIT_MARGIN)) ? 32'hFFFF_FFFF
                : scan_best_pr + psae_pkg::ADMIT_MARGIN;
   assign touch_pr = psae_pkg::eff_prio(r_prio, r_touch, frame_ff);

   // read addresses follow the phase
   always_comb begin
      case (state_ff)
         ST_SCAN:   s_raddr = scan_addr;
         ST_RMW_RD: s_raddr = tgt_ff;
         default:   s_raddr = sidx_ff;
      endcase
      m_raddr = (state_ff == ST_OLD_RD) ? old_ff : chunk_ff;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      chunk_in       = chunk_ff;
      sidx_in        = sidx_ff;
      want_in        = want_ff;
      pin_in         = pin_ff;
      tgt_in         = tgt_ff;
      admit_in       = admit_ff;
      old_in         = old_ff;
      res_status_in  = res_status_ff;
      res_chosen_in  = res_chosen_ff;
      res_dv_in      = res_dv_ff;
      res_dc_in      = res_dc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_dv_in      = rsp_dv_ff;
      rsp_dc_in      = rsp_dc_ff;
      rsp_res_in     = rsp_res_ff;
      frame_in       = frame_ff;
      use_clock_in   = use_clock_ff;
      resident_in    = resident_ff;
      protect_cfg_in = protect_cfg_ff;
      chunks_cfg_in  = chunks_cfg_ff;
      pages_cfg_in   = pages_cfg_ff;
      clr_in         = clr_ff;
      slot_vld_in    = slot_vld_ff;
      vld_q_in       = slot_vld_ff[s_raddr];

      s_we       = 1'b0;
      s_waddr    = tgt_ff;
      m_we       = 1'b0;
      m_waddr    = chunk_ff;
      m_wdata    = {1'b1, sidx_ff};
      scan_start = 1'b0;

      w_cv    = r_cv;
      w_chunk = r_chunk;
      w_lv    = r_lv;
      w_load  = r_load;
      w_pin   = r_pin;
      w_prot  = r_prot;
      w_stamp = r_stamp;
      w_prio  = r_prio;
      w_touch = r_touch;

      // output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_ff;
            m_wdata = '0;
            clr_in  = clr_ff + CW'(1);
            if (clr_ff == CW'(NUM_CHUNKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               chunk_in = req_chunk_id;
               sidx_in  = req_slot_index;
               want_in  = req_want_priority;
               pin_in   = req_pin_request;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // map entry and named slot come back next cycle
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            res_status_in = psae_pkg::STAT_INVALID;
            res_chosen_in = '0;
            res_dv_in     = 1'b0;
            res_dc_in     = '0;
            state_in      = ST_RESP;
            case (mode_ff)
               psae_pkg::MODE_REQUEST: begin
                  if (chunk_ok && (pages != '0)) begin
                     if (map_cur_ok) begin
                        // already resident: refresh stamp and pin
                        tgt_in   = m_rdata[SW-1:0];
                        admit_in = 1'b0;
                        state_in = ST_RMW_RD;
                     end else begin
                        scan_start = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
               end
               psae_pkg::MODE_TICK: begin
                  frame_in      = frame_ff + 32'd1;
                  res_status_in = psae_pkg::STAT_DONE;
               end
               psae_pkg::MODE_UP_DONE: begin
                  if (chunk_ok && sidx_ok && (load_match || chunk_match)) begin
                     res_status_in = psae_pkg::STAT_DONE;
                     res_chosen_in = sidx_ff;
                     s_we          = 1'b1;
                     s_waddr       = sidx_ff;
                     use_clock_in  = next_stamp;
                     w_stamp       = next_stamp;
                     w_lv          = 1'b0;
                     w_load        = '0;
                     if (!(chunk_match && (m_rdata == {1'b1, sidx_ff}))) begin
                        // publish, displacing any old resident
                        w_cv    = 1'b1;
                        w_chunk = chunk_ff;
                        if (frame_ff != 32'd0) begin
                           w_prot = frame_ff + 32'(protect_cfg_ff);
                        end
                        m_we = 1'b1;
                        if (r_cv) begin
                           resident_in = resident_ff - PCW'(resident_ff != '0) + PCW'(1);
                           res_dv_in   = 1'b1;
                           res_dc_in   = r_chunk;
                           if (r_chunk != chunk_ff) begin
                              old_in   = r_chunk;
                              state_in = ST_OLD_RD;
                           end
                        end else begin
                           resident_in = resident_ff + PCW'(1);
                        end
                     end
                  end
               end
               psae_pkg::MODE_UP_FAIL: begin
                  if (chunk_ok && sidx_ok) begin
                     res_status_in = psae_pkg::STAT_DONE;
                     if (load_match) begin
                        s_we    = 1'b1;
                        s_waddr = sidx_ff;
                        w_lv    = 1'b0;
                        w_load  = '0;
                     end
                  end
               end
               psae_pkg::MODE_TOUCH: begin
                  if (chunk_ok) begin
                     res_status_in = psae_pkg::STAT_DONE;
                     if (map_cur_ok) begin
                        tgt_in   = m_rdata[SW-1:0];
                        state_in = ST_RMW_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_OLD_RD: begin
            state_in = ST_OLD_WR;
         end
         ST_OLD_WR: begin
            // drop the displaced chunk's mapping if it still points here
            if (m_rdata == {1'b1, sidx_ff}) begin
               m_we    = 1'b1;
               m_waddr = old_ff;
               m_wdata = '0;
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RESP;
               if (scan_flags.found_load) begin
                  res_status_in = psae_pkg::STAT_ACTIVE;
                  res_chosen_in = scan_load;
               end else if (scan_flags.found_free) begin
                  tgt_in   = scan_free;
                  admit_in = 1'b1;
                  state_in = ST_RMW_RD;
               end else if (scan_flags.have_best) begin
                  if ((frame_ff != 32'd0) && !pin_ff && (want_ff <= bar)) begin
                     res_status_in = psae_pkg::STAT_REFUSED;
                  end else begin
                     tgt_in   = scan_best;
                     admit_in = 1'b1;
                     state_in = ST_RMW_RD;
                  end
               end else begin
                  res_status_in = psae_pkg::STAT_NO_SLOT;
               end
            end
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            s_we          = 1'b1;
            use_clock_in  = next_stamp;
            w_stamp       = next_stamp;
            res_chosen_in = tgt_ff;
            state_in      = ST_RESP;
            if (mode_ff == psae_pkg::MODE_TOUCH) begin
               w_prot        = frame_ff + 32'(protect_cfg_ff);
               w_prio        = (touch_pr > want_ff) ? touch_pr : want_ff;
               w_touch       = frame_ff;
               res_status_in = psae_pkg::STAT_DONE;
            end else if (admit_ff) begin
               // reserve the slot for the upload
               w_lv          = 1'b1;
               w_load        = chunk_ff;
               w_prio        = want_ff;
               w_touch       = frame_ff;
               w_pin         = r_pin || pin_ff;
               res_status_in = psae_pkg::STAT_ADMITTED;
            end else begin
               w_pin         = r_pin || pin_ff;
               res_status_in = psae_pkg::STAT_ACTIVE;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_chosen_in = res_chosen_ff;
               rsp_dv_in     = res_dv_ff;
               rsp_dc_in     = res_dc_ff;
               rsp_res_in    = resident_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (s_we) begin
         slot_vld_in[s_waddr] = 1'b1;
      end

      // configuration writes; count changes restart the tables
      if (csr_wr_en) begin
         case (csr_index)
            psae_pkg::REG_PROTECT: protect_cfg_in = csr_wdata[psae_pkg::PROTECT_W-1:0];
            psae_pkg::REG_CHUNKS:  chunks_cfg_in  = csr_wdata[psae_pkg::CHUNKS_W-1:0];
            psae_pkg::REG_PAGES:   pages_cfg_in   = csr_wdata[psae_pkg::PAGES_W-1:0];
            default: begin
            end
         endcase
      end
      if (cfg_clear) begin
         slot_vld_in  = '0;
         frame_in     = '0;
         use_clock_in = '0;
         resident_in  = '0;
         clr_in       = '0;
         state_in     = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         slot_vld_ff    <= '0;
         frame_ff       <= '0;
         use_clock_ff   <= '0;
         resident_ff    <= '0;
         protect_cfg_ff <= psae_pkg::PROTECT_RST;
         chunks_cfg_ff  <= psae_pkg::CHUNKS_RST;
         pages_cfg_ff   <= psae_pkg::PAGES_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         slot_vld_ff    <= slot_vld_in;
         frame_ff       <= frame_in;
         use_clock_ff   <= use_clock_in;
         resident_ff    <= resident_in;
         protect_cfg_ff <= protect_cfg_in;
         chunks_cfg_ff  <= chunks_cfg_in;
         pages_cfg_ff   <= pages_cfg_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_chosen_ff  <= rsp_chosen_in;
         rsp_dv_ff      <= rsp_dv_in;
         rsp_dc_ff      <= rsp_dc_in;
         rsp_res_ff     <= rsp_res_in;
      end
      mode_ff       <= mode_in;
      chunk_ff      <= chunk_in;
      sidx_ff       <= sidx_in;
      want_ff       <= want_in;
      pin_ff        <= pin_in;
      tgt_ff        <= tgt_in;
      admit_ff      <= admit_in;
      old_ff        <= old_in;
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      res_dv_ff     <= res_dv_in;
      res_dc_ff     <= res_dc_in;
      vld_q_ff      <= vld_q_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_slot     = rsp_chosen_ff;
   assign rsp_displaced_valid = rsp_dv_ff;
   assign rsp_displaced_chunk = rsp_dc_ff;
   assign rsp_resident_count  = rsp_res_ff;

   `PSAE_ASSERT_NOW(a_resident_bound, 1'b1, resident_ff <= PCW'(NUM_PAGES), "resident count above page count")
   `PSAE_ASSERT_NEXT(a_accept_fetch, accept && !csr_wr_en, state_ff == ST_FETCH, "accepted word not fetched")
   `PSAE_ASSERT_NOW(a_scan_phase, scan_done, state_ff == ST_SCAN, "scan finished outside scan phase")
   `PSAE_ASSERT_NOW(a_displace_done, rsp_valid_ff && rsp_dv_ff, rsp_status_ff == psae_pkg::STAT_DONE, "displacement without publish")

endmodule

>>> tb/page_slot_admission_eviction_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// page_slot_admission_eviction_test
// drives event words into the page slot block under random idling and
// stalls, predicts untyped result words from a private copy of the slot
// table and chunk map (typed rows carry their own), and checks each result word field by field
// ---------------------------------------------------------------------------
module page_slot_admission_eviction_test;
   import psae_pkg::*;

   localparam int PAGES      = 64;
   localparam int CHUNKS     = 4096;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 100;

   // modes the block does not decode
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic        disp_valid;
      logic [11:0] disp_chunk;
      logic [6:0]  resident;
   } outcome_type;

   typedef struct {
      logic [2:0]  mode;
      logic [11:0] chunk;
      logic [5:0]  slot;
      logic [31:0] prio;
      logic        pin;
      bit          typed;
      outcome_type result;
   } event_row_type;

   typedef struct {
      logic [11:0] chunk;
      logic [5:0]  slot;
   } upload_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = 3'd0;
   logic [11:0] req_chunk_id = '0;
   logic [5:0]  req_slot_index = '0;
   logic [31:0] req_want_priority = '0;
   logic        req_pin_request = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_chosen_slot;
   logic        rsp_displaced_valid;
   logic [11:0] rsp_displaced_chunk;
   logic [6:0]  rsp_resident_count;
   logic        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block: slot records, chunk map, counters, registers
   logic [12:0] page_owner [PAGES];    // bit 12 valid
   logic [12:0] page_pending [PAGES];  // bit 12 valid
   logic        page_locked [PAGES];
   logic [31:0] shield_until [PAGES];
   logic [31:0] last_use [PAGES];
   logic [31:0] page_prio [PAGES];
   logic [31:0] page_touch [PAGES];
   logic [7:0]  chunk_home [CHUNKS];   // bit 7 valid
   logic [31:0] frame_now;
   logic [31:0] use_tick;
   logic [6:0]  resident_now;
   logic [7:0]  cfg_protect;
   logic [12:0] cfg_chunks;
   logic [6:0]  cfg_pages;

   outcome_type   expected_words [$];
   upload_type    open_uploads [$];
   event_row_type directed [$];
   int            fail_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            quiet_cycles = 0;
   outcome_type   head_word;

   page_slot_admission_eviction i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_chunk_id(req_chunk_id), .req_slot_index(req_slot_index),
      .req_want_priority(req_want_priority), .req_pin_request(req_pin_request),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_chosen_slot(rsp_chosen_slot), .rsp_displaced_valid(rsp_displaced_valid),
      .rsp_displaced_chunk(rsp_displaced_chunk),
      .rsp_resident_count(rsp_resident_count),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------
   function automatic void clear_shadow();
      for (int i = 0; i < PAGES; i++) begin
         page_owner[i] = '0; page_pending[i] = '0; page_locked[i] = 1'b0;
         shield_until[i] = '0; last_use[i] = '0; page_prio[i] = '0;
         page_touch[i] = '0;
      end
      for (int i = 0; i < CHUNKS; i++) chunk_home[i] = '0;
      frame_now = '0;
      use_tick = '0;
      resident_now = '0;
   endfunction

   function automatic int live_chunks();
      return (cfg_chunks < CHUNKS) ? int'(cfg_chunks) : CHUNKS;
   endfunction

   function automatic int live_pages();
      int p;
      p = (cfg_pages < PAGES) ? int'(cfg_pages) : PAGES;
      return (p < live_chunks()) ? p : live_chunks();
   endfunction

   function automatic logic [31:0] stamp_next();
      use_tick = use_tick + 32'd1;
      return use_tick;
   endfunction

   // priority counts as zero once the page has idled past the window
   function automatic logic [31:0] aged_prio(int s);
      logic [31:0] t;
      logic [31:0] age;
      t = (page_touch[s] < frame_now) ? page_touch[s] : frame_now;
      age = frame_now - t;
      return (age > IDLE_FREE_FRAMES) ? 32'd0 : page_prio[s];
   endfunction

   // lowest free slot, else cheapest evictable one (oldest use on a tie)
   function automatic int pick_victim(int pages);
      int          best;
      logic [31:0] best_prio;
      logic [32:0] best_stamp;
      logic [31:0] pr;
      best = pages;
      best_prio = '1;
      best_stamp = '1;
      for (int s = 0; s < pages; s++)
         if (!page_owner[s][12] && !page_pending[s][12]) return s;
      for (int s = 0; s < pages; s++) begin
         if (page_locked[s] || page_pending[s][12]) continue;
         if (shield_until[s] > frame_now) continue;
         pr = (frame_now > 0) ? aged_prio(s) : 32'd0;
         if (pr < best_prio || (pr == best_prio && {1'b0, last_use[s]} < best_stamp)) begin
            best_prio = pr;
            best_stamp = {1'b0, last_use[s]};
            best = s;
         end
      end
      return best;
   endfunction

   function automatic outcome_type predict_event(logic [2:0] mode, logic [11:0] chunk,
                                                 logic [5:0] sidx, logic [31:0] want,
                                                 logic pin);
      outcome_type o;
      int          pages;
      bit          chunk_ok;
      bit          settled;
      bit          refuse;
      int          s;
      int          cur;
      logic [12:0] tag;
      logic [11:0] old;
      logic [31:0] r;
      logic [31:0] bar;
      upload_type  u;
      pages = live_pages();
      chunk_ok = int'(chunk) < live_chunks();
      tag = {1'b1, chunk};
      o = '{status: STAT_INVALID, slot: '0, disp_valid: 1'b0, disp_chunk: '0,
            resident: '0};
      case (mode)
         MODE_REQUEST: begin
            if (chunk_ok && pages > 0) begin
               settled = 1'b0;
               cur = int'(chunk_home[chunk][6:0]);
               if (chunk_home[chunk][7] && cur < pages) begin
                  last_use[cur] = stamp_next();
                  page_locked[cur] = page_locked[cur] | pin;
                  o.status = STAT_ACTIVE;
                  o.slot = cur;
                  settled = 1'b1;
               end
               for (int k = 0; !settled && k < pages; k++)
                  if (page_pending[k] == tag) begin
                     o.status = STAT_ACTIVE;
                     o.slot = k;
                     settled = 1'b1;
                  end
               if (!settled) begin
                  s = pick_victim(pages);
                  if (s >= pages) begin
                     o.status = STAT_NO_SLOT;
                  end else begin
                     refuse = 1'b0;
                     if (frame_now > 0 && !pin && page_owner[s][12]) begin
                        r = aged_prio(s);
                        bar = (r > 32'hFFFF_FFFF - ADMIT_MARGIN) ? 32'hFFFF_FFFF
                                                                  : r + ADMIT_MARGIN;
                        refuse = want <= bar;
                     end
                     if (refuse) begin
                        o.status = STAT_REFUSED;
                     end else begin
                        page_pending[s] = tag;
                        last_use[s] = stamp_next();
                        page_prio[s] = want;
                        page_touch[s] = frame_now;
                        page_locked[s] = page_locked[s] | pin;
                        o.status = STAT_ADMITTED;
                        o.slot = s;
                        u.chunk = chunk;
                        u.slot = s;
                        open_uploads.push_back(u);
                     end
                  end
               end
            end
         end
         MODE_TICK: begin
            frame_now = frame_now + 32'd1;
            o.status = STAT_DONE;
         end
         MODE_UP_DONE: begin
            if (chunk_ok && int'(sidx) < pages &&
                (page_pending[sidx] == tag || page_owner[sidx] == tag)) begin
               o.status = STAT_DONE;
               o.slot = sidx;
               if (page_owner[sidx] == tag && chunk_home[chunk] == {1'b1, 1'b0, sidx}) begin
                  page_pending[sidx] = '0;
                  last_use[sidx] = stamp_next();
               end else begin
                  // publish over a resident page drops the old chunk's mapping
                  if (page_owner[sidx][12]) begin
                     old = page_owner[sidx][11:0];
                     if (chunk_home[old] == {1'b1, 1'b0, sidx}) chunk_home[old] = '0;
                     if (resident_now > 0) resident_now = resident_now - 7'd1;
                     o.disp_valid = 1'b1;
                     o.disp_chunk = old;
                  end
                  page_owner[sidx] = tag;
                  page_pending[sidx] = '0;
                  last_use[sidx] = stamp_next();
                  if (frame_now > 0) shield_until[sidx] = frame_now + cfg_protect;
                  chunk_home[chunk] = {1'b1, 1'b0, sidx};
                  resident_now = resident_now + 7'd1;
               end
            end
         end
         MODE_UP_FAIL: begin
            if (chunk_ok && int'(sidx) < pages) begin
               if (page_pending[sidx] == tag) page_pending[sidx] = '0;
               o.status = STAT_DONE;
            end
         end
         MODE_TOUCH: begin
            if (chunk_ok) begin
               o.status = STAT_DONE;
               cur = int'(chunk_home[chunk][6:0]);
               if (chunk_home[chunk][7] && cur < pages) begin
                  shield_until[cur] = frame_now + cfg_protect;
                  last_use[cur] = stamp_next();
                  r = aged_prio(cur);
                  page_prio[cur] = (r > want) ? r : want;
                  page_touch[cur] = frame_now;
                  o.slot = cur;
               end
            end
         end
         default: ;
      endcase
      o.resident = resident_now;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void add_row(logic [2:0] mode, logic [11:0] chunk, logic [5:0] slot,
                                   logic [31:0] prio, logic pin, bit typed,
                                   logic [2:0] st, logic [5:0] chosen, logic [6:0] res);
      event_row_type row;
      row.mode = mode; row.chunk = chunk; row.slot = slot; row.prio = prio;
      row.pin = pin; row.typed = typed;
      row.result = '{status: st, slot: chosen, disp_valid: 1'b0, disp_chunk: '0,
                     resident: res};
      directed.push_back(row);
   endfunction

   function automatic logic [31:0] draw_prio();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return ADMIT_MARGIN + $urandom_range(2) - 32'd1;
         3: return $urandom_range(16'hFFFF);
         default: return $urandom;
      endcase
   endfunction

   // hand one word to the block, then predict or take the typed result
   task automatic send_word(event_row_type row);
      outcome_type o;
      req_valid <= 1'b1;
      req_mode <= row.mode;
      req_chunk_id <= row.chunk;
      req_slot_index <= row.slot;
      req_want_priority <= row.prio;
      req_pin_request <= row.pin;
      do @(posedge clock); while (req_stall);
      o = predict_event(row.mode, row.chunk, row.slot, row.prio, row.pin);
      expected_words.push_back(row.typed ? row.result : o);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // write one register once the block has drained
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_PROTECT: cfg_protect = value[PROTECT_W-1:0];
         REG_CHUNKS: begin
            cfg_chunks = value[CHUNKS_W-1:0];
            clear_shadow();
            open_uploads.delete();
         end
         default: begin
            cfg_pages = value[PAGES_W-1:0];
            clear_shadow();
            open_uploads.delete();
         end
      endcase
      // map sweep holds off new words
      repeat (2) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly well-formed traffic over a small chunk pool, some noise
   task automatic random_words(int count);
      event_row_type row;
      upload_type    u;
      int            pool;
      int            pick;
      int            k;
      pool = 2 * live_pages() + 2;
      if (pool > live_chunks()) pool = live_chunks();
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(4))
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
               default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
         end
         row.typed = 1'b0;
         row.chunk = $urandom_range(pool - 1);
         row.slot = $urandom_range(live_pages() - 1);
         row.prio = draw_prio();
         row.pin = ($urandom_range(15) == 0);
         pick = $urandom_range(99);
         if (pick < 32) begin
            row.mode = MODE_REQUEST;
         end else if (pick < 55) begin
            row.mode = MODE_UP_DONE;
            if (open_uploads.size() != 0) begin
               k = $urandom_range(open_uploads.size() - 1);
               u = open_uploads[k];
               open_uploads.delete(k);
               row.chunk = u.chunk;
               row.slot = u.slot;
            end
         end else if (pick < 62) begin
            row.mode = MODE_UP_FAIL;
            if (open_uploads.size() != 0 && $urandom_range(1)) begin
               k = $urandom_range(open_uploads.size() - 1);
               u = open_uploads[k];
               open_uploads.delete(k);
               row.chunk = u.chunk;
               row.slot = u.slot;
            end
         end else if (pick < 76) begin
            row.mode = MODE_TOUCH;
         end else if (pick < 90) begin
            row.mode = MODE_TICK;
         end else if (pick < 93) begin
            row.mode = $urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST);
         end else begin
            // noise: any field value, mostly out of range
            row.mode = $urandom_range(MODE_TOUCH);
            row.chunk = $urandom;
            row.slot = $urandom;
            row.prio = $urandom;
            row.pin = $urandom_range(1);
         end
         send_word(row);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls and field checks
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with none expected, status %0d", rsp_status);
            fail_count++;
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_status !== head_word.status) begin
               $error("status expected %0d got %0d", head_word.status, rsp_status);
               fail_count++;
            end
            if (rsp_chosen_slot !== head_word.slot) begin
               $error("chosen_slot expected %0d got %0d", head_word.slot, rsp_chosen_slot);
               fail_count++;
            end
            if (rsp_displaced_valid !== head_word.disp_valid) begin
               $error("displaced_valid expected %0d got %0d", head_word.disp_valid,
                      rsp_displaced_valid);
               fail_count++;
            end
            if (rsp_displaced_chunk !== head_word.disp_chunk) begin
               $error("displaced_chunk expected %0d got %0d", head_word.disp_chunk,
                      rsp_displaced_chunk);
               fail_count++;
            end
            if (rsp_resident_count !== head_word.resident) begin
               $error("resident_count expected %0d got %0d", head_word.resident,
                      rsp_resident_count);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog: cycles with no handshake on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("page_slot_admission_eviction_test: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_protect = PROTECT_RST;
      cfg_chunks = CHUNKS_RST;
      cfg_pages = PAGES_RST;
      clear_shadow();

      // frame zero, all 64 slots free
      add_row(MODE_REQUEST, 12'd0, 6'd0, 32'd0, 1'b0, 1, STAT_ADMITTED, 6'd0, 7'd0);
      // chunk already loading
      add_row(MODE_REQUEST, 12'd0, 6'd0, 32'd5, 1'b0, 1, STAT_ACTIVE, 6'd0, 7'd0);
      add_row(MODE_UP_DONE, 12'd0, 6'd0, 32'd0, 1'b0, 1, STAT_DONE, 6'd0, 7'd1);
      add_row(MODE_REQUEST, 12'd4095, 6'd0, 32'hFFFF_FFFF, 1'b1, 1, STAT_ADMITTED,
              6'd1, 7'd1);
      // failed upload drops the reservation, then its done word is stale
      add_row(MODE_UP_FAIL, 12'd4095, 6'd1, 32'd0, 1'b0, 1, STAT_DONE, 6'd0, 7'd1);
      add_row(MODE_UP_DONE, 12'd4095, 6'd1, 32'd0, 1'b0, 1, STAT_INVALID, 6'd0, 7'd1);
      add_row(MODE_UP_DONE, 12'd5, 6'd63, 32'd0, 1'b0, 1, STAT_INVALID, 6'd0, 7'd1);
      add_row(MODE_TOUCH, 12'd0, 6'd0, 32'hFFFF_FFFF, 1'b1, 1, STAT_DONE, 6'd0, 7'd1);
      // touch of a chunk that is not resident
      add_row(MODE_TOUCH, 12'd77, 6'd0, 32'd9, 1'b0, 1, STAT_DONE, 6'd0, 7'd1);
      add_row(MODE_SPARE_FIRST, 12'd1, 6'd1, 32'd1, 1'b0, 1, STAT_INVALID, 6'd0, 7'd1);
      add_row(MODE_SPARE_LAST, 12'd1, 6'd1, 32'd1, 1'b1, 1, STAT_INVALID, 6'd0, 7'd1);
      // mapped request reports the holding slot
      add_row(MODE_REQUEST, 12'd0, 6'd0, 32'd0, 1'b1, 1, STAT_ACTIVE, 6'd0, 7'd1);
      add_row(MODE_TICK, 12'd0, 6'd0, 32'd0, 1'b0, 1, STAT_DONE, 6'd0, 7'd1);
      // past frame zero: leave the rest to the shadow model
      add_row(MODE_REQUEST, 12'd100, 6'd0, 32'd0, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_UP_DONE, 12'd100, 6'd1, 32'd0, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_UP_DONE, 12'd100, 6'd1, 32'd0, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_TOUCH, 12'd100, 6'd0, ADMIT_MARGIN, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_UP_FAIL, 12'd100, 6'd63, 32'd0, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_REQUEST, 12'd4095, 6'd0, 32'hFFFF_FFFF, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);
      add_row(MODE_UP_DONE, 12'd4095, 6'd2, 32'd0, 1'b0, 0, STAT_DONE, 6'd0, 7'd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // first word waits out the map sweep
      foreach (directed[i]) send_word(directed[i]);

      random_words(180);
      // tight table: few pages so eviction and the margin get exercised
      write_reg(REG_PROTECT, 13'd0);
      write_reg(REG_PAGES, 13'd4);
      random_words(150);
      // one chunk, one page, maximum shielding
      write_reg(REG_PROTECT, 13'd255);
      write_reg(REG_CHUNKS, 13'd1);
      write_reg(REG_PAGES, 13'd1);
      random_words(50);
      // page count clamped by the chunk count
      write_reg(REG_PROTECT, 13'd3);
      write_reg(REG_CHUNKS, 13'd6);
      write_reg(REG_PAGES, 13'd64);
      random_words(100);
      write_reg(REG_CHUNKS, 13'd4096);
      write_reg(REG_PAGES, 13'd8);
      random_words(120);

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("page_slot_admission_eviction_test: clean");
      else
         $display("page_slot_admission_eviction_test: errors");
      $finish;
   end

endmodule
